/* hdl/mandelbrot_escape_time_pixel_defines.svh */
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: assertion macros
// Shared concurrent assertion forms for the block's modules.
// ----------------------------------------------------------------------------
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_DEFINES_SVH

// implication checked on every edge outside reset
`define MEP_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define MEP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

/* hdl/mep_pkg.sv */
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: package
// Payload types, controller states and command/status structs.
// ----------------------------------------------------------------------------
package mep_pkg;

  // pixel coordinate width
  localparam int DIM_BITS = 12;

  typedef struct packed {
    logic [DIM_BITS-1:0] pixel_x;
    logic [DIM_BITS-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] iterations;
    logic        inside_res;
  } pix_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_CMAP,
    ST_MUL,
    ST_ITER,
    ST_TDIV,
    ST_COL1,
    ST_COL2,
    ST_DONE
  } ctl_state_e;

  // register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  typedef struct packed {
    logic load;      // capture item, start coordinate division
    logic div_step;  // one quotient bit for both coordinates
    logic cmap;      // form c
    logic mul;       // register squares and cross product
    logic iter;      // finish a step
    logic tdiv_load;
    logic tdiv_step;
    logic col1;
    logic col2;
    logic done;
  } ctl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic escape;
    logic at_limit;
    logic tdiv_last;
  } dp_stat_t;

endpackage

/* hdl/mep_ctrl.sv */
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: controller
// Sequences coordinate division, iteration and colouring.
// ----------------------------------------------------------------------------
module mep_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  mep_pkg::dp_stat_t   stat_i,
  output mep_pkg::ctl_cmd_t   cmd_o,
  output logic                busy_o
);

  mep_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mep_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mep_pkg::ST_IDLE: if (start_i) state_d = mep_pkg::ST_DIV;
      mep_pkg::ST_DIV:  if (stat_i.div_last) state_d = mep_pkg::ST_CMAP;
      mep_pkg::ST_CMAP: state_d = mep_pkg::ST_MUL;
      mep_pkg::ST_MUL: begin
        if (stat_i.at_limit) state_d = mep_pkg::ST_DONE;
        else if (stat_i.escape) state_d = mep_pkg::ST_TDIV;
        else state_d = mep_pkg::ST_ITER;
      end
      mep_pkg::ST_ITER: state_d = mep_pkg::ST_MUL;
      mep_pkg::ST_TDIV: if (stat_i.tdiv_last) state_d = mep_pkg::ST_COL1;
      mep_pkg::ST_COL1: state_d = mep_pkg::ST_COL2;
      mep_pkg::ST_COL2: state_d = mep_pkg::ST_DONE;
      mep_pkg::ST_DONE: state_d = mep_pkg::ST_IDLE;
      default:          state_d = mep_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      mep_pkg::ST_IDLE: cmd_o.load = start_i;
      mep_pkg::ST_DIV:  cmd_o.div_step = 1'b1;
      mep_pkg::ST_CMAP: cmd_o.cmap = 1'b1;
      mep_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        cmd_o.tdiv_load = !stat_i.at_limit && stat_i.escape;
      end
      mep_pkg::ST_ITER: cmd_o.iter = 1'b1;
      mep_pkg::ST_TDIV: cmd_o.tdiv_step = 1'b1;
      mep_pkg::ST_COL1: cmd_o.col1 = 1'b1;
      mep_pkg::ST_COL2: cmd_o.col2 = 1'b1;
      mep_pkg::ST_DONE: cmd_o.done = 1'b1;
      default: cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != mep_pkg::ST_IDLE);

endmodule

/* hdl/mep_dpath.sv */
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: datapath
// Serial coordinate dividers, complex square step, colour divider.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_defines.svh"

module mep_dpath #(
  parameter int FRAC_BITS = 28
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mep_pkg::ctl_cmd_t   cmd_i,
  input  mep_pkg::pix_in_t    pix_i,
  input  logic [12:0]         width_i,
  input  logic [12:0]         height_i,
  input  logic [15:0]         limit_i,
  output mep_pkg::dp_stat_t   stat_o,
  output mep_pkg::pix_out_t   res_o,
  output logic                res_valid_o
);

  localparam int W   = FRAC_BITS + 4;   // fixed-point word
  localparam int PW  = 2 * W;
  localparam int DW  = mep_pkg::DIM_BITS + 1;
  localparam int NW  = mep_pkg::DIM_BITS + 4;    // numerator and divisor width
  localparam int QW  = NW + FRAC_BITS;  // quotient width
  localparam int CW  = $clog2(QW + 1);

  logic [DW-1:0] w_m1, h_m1, xs, ys;
  logic [DW-1:0] w_eff, h_eff;
  logic [mep_pkg::DIM_BITS-1:0] xin, yin;

  assign w_eff = (width_i[DW-1:0]  < DW'(2)) ? DW'(2) : width_i[DW-1:0];
  assign h_eff = (height_i[DW-1:0] < DW'(2)) ? DW'(2) : height_i[DW-1:0];
  assign w_m1  = w_eff - DW'(1);
  assign h_m1  = h_eff - DW'(1);
  assign xin   = pix_i.pixel_x[mep_pkg::DIM_BITS-1:0];
  assign yin   = pix_i.pixel_y[mep_pkg::DIM_BITS-1:0];
  assign xs    = ({1'b0, xin} > w_m1) ? w_m1 : {1'b0, xin};
  assign ys    = ({1'b0, yin} > h_m1) ? h_m1 : {1'b0, yin};

  // restoring dividers: numerator bits fed MSB first, then FRAC_BITS zeros
  logic [QW-1:0] xn_q, yn_q, xq_q, yq_q;
  logic [NW:0]   xr_q, yr_q;
  logic [NW-1:0] xd_q, yd_q;
  logic [CW-1:0] cnt_q;
  logic [NW:0]   xr_sh, yr_sh;
  logic          xge, yge;

  assign xr_sh = {xr_q[NW-1:0], xn_q[QW-1]};
  assign yr_sh = {yr_q[NW-1:0], yn_q[QW-1]};
  assign xge   = xr_sh >= {1'b0, xd_q};
  assign yge   = yr_sh >= {1'b0, yd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xn_q <= {NW'(xs) * NW'(7), {FRAC_BITS{1'b0}}};
      yn_q <= {NW'(ys) * NW'(12), {FRAC_BITS{1'b0}}};
      xd_q <= NW'(w_m1) * NW'(2);
      yd_q <= NW'(h_m1) * NW'(5);
      xr_q <= '0;
      yr_q <= '0;
      xq_q <= '0;
      yq_q <= '0;
    end else if (cmd_i.div_step) begin
      xn_q <= {xn_q[QW-2:0], 1'b0};
      yn_q <= {yn_q[QW-2:0], 1'b0};
      xr_q <= xge ? xr_sh - {1'b0, xd_q} : xr_sh;
      yr_q <= yge ? yr_sh - {1'b0, yd_q} : yr_sh;
      xq_q <= {xq_q[QW-2:0], xge};
      yq_q <= {yq_q[QW-2:0], yge};
    end
  end

  assign stat_o.div_last = (cnt_q == CW'(QW - 1));

  // constants: 5*2^(F-1) and floor(6*2^F/5)
  localparam logic [W-1:0] CRE_OFF = W'(5) << (FRAC_BITS - 1);
  localparam logic [W+3:0] SIX_SC  = (W+4)'(6) << FRAC_BITS;
  localparam logic [W-1:0] CIM_OFF = W'(SIX_SC / (W+4)'(5));
  localparam logic [PW-1:0] FOUR   = PW'(4) << FRAC_BITS;

  logic signed [W-1:0] cx_q, cy_q, zx_q, zy_q;
  logic signed [PW-1:0] xx_q, yy_q, xy_q;
  logic [15:0] iter_q;

  logic signed [PW-1:0] pxx, pyy, pxy;
  assign pxx = PW'(zx_q) * PW'(zx_q);
  assign pyy = PW'(zy_q) * PW'(zy_q);
  assign pxy = PW'(zx_q) * PW'(zy_q);

  logic signed [PW-1:0] sxx, syy, sxy, sum;
  assign sxx = pxx >>> FRAC_BITS;
  assign syy = pyy >>> FRAC_BITS;
  assign sxy = pxy >>> FRAC_BITS;
  assign sum = sxx + syy;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmap) begin
      cx_q <= W'(xq_q) - CRE_OFF;
      cy_q <= W'(yq_q) - CIM_OFF;
      zx_q <= '0;
      zy_q <= '0;
      iter_q <= '0;
    end else if (cmd_i.mul) begin
      xx_q <= sxx;
      yy_q <= syy;
      xy_q <= sxy;
    end else if (cmd_i.iter) begin
      zx_q <= W'(xx_q - yy_q) + cx_q;
      zy_q <= W'(xy_q <<< 1) + cy_q;
      iter_q <= iter_q + 16'd1;
    end
  end

  assign stat_o.at_limit = (iter_q >= limit_i);
  assign stat_o.escape   = (sum > $signed(FOUR));

  // t = iter*255/limit, serial over 24 numerator bits
  logic [23:0] tn_q, tq_q;
  logic [16:0] tr_q;
  logic [4:0]  tc_q;
  logic [16:0] tr_sh;
  logic        tge;
  assign tr_sh = {tr_q[15:0], tn_q[23]};
  assign tge   = tr_sh >= {1'b0, limit_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0;
    end else if (cmd_i.tdiv_load) begin
      tc_q <= '0;
    end else if (cmd_i.tdiv_step) begin
      tc_q <= tc_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tdiv_load) begin
      tn_q <= 24'(iter_q) * 24'd255;
      tr_q <= '0;
      tq_q <= '0;
    end else if (cmd_i.tdiv_step) begin
      tn_q <= {tn_q[22:0], 1'b0};
      tr_q <= tge ? tr_sh - {1'b0, limit_i} : tr_sh;
      tq_q <= {tq_q[22:0], tge};
    end
  end

  assign stat_o.tdiv_last = (tc_q == 5'd23);

  // colour: t < 255 when outside, divisions by constants via reciprocals
  logic [7:0]  t;
  logic [15:0] tt_q, tb_q;
  logic [7:0]  b_q, g_q, r_q;
  logic [31:0] gmul, bmul;
  logic [15:0] rmul;
  assign t    = tq_q[7:0];
  assign gmul = 32'(tt_q) * 32'd32897;   // /255, exact for t*t and t*120
  assign bmul = 32'(tb_q) * 32'd32897;
  assign rmul = 16'(t) * 16'd171;        // /3 for values below 256

  always_ff @(posedge clk_i) begin
    if (cmd_i.col1) begin
      tt_q <= 16'(t) * 16'(t);
      tb_q <= 16'(t) * 16'd120;
    end
    if (cmd_i.col2) begin
      g_q <= gmul[30:23];
      b_q <= 8'd80 + bmul[30:23];
      r_q <= 8'd255 - 8'(rmul[15:9]);
    end
  end

  logic rv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= cmd_i.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.done) begin
      res_o.inside_res <= stat_o.at_limit;
      res_o.iterations <= iter_q;
      res_o.blue  <= stat_o.at_limit ? 8'd8  : b_q;
      res_o.green <= stat_o.at_limit ? 8'd8  : g_q;
      res_o.red   <= stat_o.at_limit ? 8'd12 : r_q;
    end
  end
  assign res_valid_o = rv_q;

  logic [8:0] cmd_vec;
  assign cmd_vec = {cmd_i.load, cmd_i.div_step, cmd_i.cmap, cmd_i.mul, cmd_i.iter,
                    cmd_i.tdiv_step, cmd_i.col1, cmd_i.col2, cmd_i.done};

  `MEP_ASSERT_NEXT(a_done_strobe, clk_i, rst_ni, cmd_i.done, res_valid_o)
  `MEP_ASSERT_IMP(a_one_cmd, clk_i, rst_ni, 1'b1, $onehot0(cmd_vec))
  `MEP_ASSERT_NEXT(a_iter_count, clk_i, rst_ni, cmd_i.iter, iter_q == $past(iter_q) + 16'd1)

endmodule

/* hdl/mandelbrot_escape_time_pixel.sv */
// Sequence: start loads the pixel, the coordinate dividers run and c is formed, then
// each iteration passes MUL and ITER; escaping points add the colour divider, COL1, COL2.
// Throughput: one pixel at a time; busy falls with the result strobe, so the next
// start can be taken while the strobe is high. Each complex step takes MUL and ITER.
// Reset: asynchronous, active low; registers return to 640, 480, 256.
// Results are strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: top level
// APB register file, controller and datapath.
// ----------------------------------------------------------------------------
`include "mandelbrot_escape_time_pixel_defines.svh"

module mandelbrot_escape_time_pixel #(
  parameter int FRAC_BITS = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  mep_pkg::pix_in_t   pix_i,
  output logic               done_o,
  output mep_pkg::pix_out_t  res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [12:0] width_q, height_q;
  logic [15:0] limit_q;
  logic        wr;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign wr  = psel && penable && pwrite;
  assign idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
      limit_q  <= 16'd256;
    end else if (wr && paddr[1:0] == 2'b00) begin
      if (idx == mep_pkg::REG_WIDTH)  width_q  <= pwdata[12:0];
      if (idx == mep_pkg::REG_HEIGHT) height_q <= pwdata[12:0];
      if (idx == mep_pkg::REG_LIMIT)  limit_q  <= pwdata[15:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (idx == mep_pkg::REG_WIDTH)       prdata = 32'(width_q);
    else if (idx == mep_pkg::REG_HEIGHT) prdata = 32'(height_q);
    else if (idx == mep_pkg::REG_LIMIT)  prdata = 32'(limit_q);
  end

  mep_pkg::ctl_cmd_t cmd;
  mep_pkg::dp_stat_t stat;

  mep_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  mep_dpath #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .pix_i      (pix_i),
    .width_i    (width_q),
    .height_i   (height_q),
    .limit_i    (limit_q),
    .stat_o     (stat),
    .res_o      (res_o),
    .res_valid_o(done_o)
  );

  `MEP_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `MEP_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_o, !busy)
  `MEP_ASSERT_IMP(a_ready_const, clk_i, rst_ni, 1'b1, pready)

endmodule

/* test/mandelbrot_escape_time_pixel_test.sv */
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel: testbench
// Drives pixel words through the command port and register settings over APB.
// Each accepted word is predicted by a fixed-point escape-time model and the
// strobed colour word is compared field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mandelbrot_escape_time_pixel_test;

  localparam int FRAC = 28;
  localparam longint unsigned CYCLE_LIMIT = 4000000;

  class pixel_scoreboard;
    logic [12:0] frame_w = 13'd640;
    logic [12:0] frame_h = 13'd480;
    logic [15:0] iter_max = 16'd256;
    mep_pkg::pix_out_t pending[$];
    int          mismatches = 0;

    function longint fx_mul(longint a, longint b);
      logic signed [127:0] p;
      p = a * b;
      p = p >>> FRAC;
      return longint'(p[63:0]);
    endfunction

    function mep_pkg::pix_out_t escape_colour(mep_pkg::pix_in_t pix);
      longint unsigned w, h, x, y, it, t;
      longint cx, cy, zx, zy, xx, yy, xy;
      mep_pkg::pix_out_t r;
      w = (frame_w < 2) ? 64'd2 : 64'(frame_w);
      h = (frame_h < 2) ? 64'd2 : 64'(frame_h);
      x = 64'(pix.pixel_x);
      y = 64'(pix.pixel_y);
      if (x > w - 1) x = w - 1;
      if (y > h - 1) y = h - 1;
      cx = longint'(((7 * x) << FRAC) / (2 * (w - 1))) - (longint'(5) <<< (FRAC - 1));
      cy = longint'(((12 * y) << FRAC) / (5 * (h - 1))) - longint'((64'd6 << FRAC) / 5);
      zx = 0;
      zy = 0;
      it = 0;
      while (it < iter_max) begin
        xx = fx_mul(zx, zx);
        yy = fx_mul(zy, zy);
        if (xx + yy > (longint'(4) <<< FRAC)) break;
        xy = fx_mul(zx, zy);
        zx = xx - yy + cx;
        zy = xy * 2 + cy;
        it++;
      end
      if (it >= iter_max) begin
        r.blue = 8'd8;
        r.green = 8'd8;
        r.red = 8'd12;
        r.inside_res = 1'b1;
      end else begin
        t = it * 255 / iter_max;
        r.blue = 8'(80 + t * 120 / 255);
        r.green = 8'(t * t / 255);
        r.red = 8'(255 - t / 3);
        r.inside_res = 1'b0;
      end
      r.iterations = it[15:0];
      return r;
    endfunction

    function void note_pixel(mep_pkg::pix_in_t pix);
      pending.push_back(escape_colour(pix));
    endfunction

    function void check_colour(mep_pkg::pix_out_t got);
      mep_pkg::pix_out_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
        return;
      end
      exp_w = pending.pop_front();
      if (got.blue !== exp_w.blue || got.green !== exp_w.green ||
          got.red !== exp_w.red || got.iterations !== exp_w.iterations ||
          got.inside_res !== exp_w.inside_res) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: exp %p got %p", exp_w, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  mep_pkg::pix_in_t  pix_i = '0;
  logic        done_o;
  mep_pkg::pix_out_t res_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  pixel_scoreboard sb = new();
  longint unsigned cycles = 0;
  int          word_no = 0;

  always #5 clk_i = ~clk_i;

  mandelbrot_escape_time_pixel DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .pix_i(pix_i),
    .done_o(done_o), .res_o(res_o), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_colour(res_o);
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      mep_pkg::REG_WIDTH:  sb.frame_w = val[12:0];
      mep_pkg::REG_HEIGHT: sb.frame_h = val[12:0];
      default:             sb.iter_max = val[15:0];
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic configure(input int w, input int h, input int lim);
    drain();
    reg_write(mep_pkg::REG_WIDTH, w);
    reg_write(mep_pkg::REG_HEIGHT, h);
    reg_write(mep_pkg::REG_LIMIT, lim);
  endtask

  task automatic send_pixel(input logic [11:0] x, input logic [11:0] y);
    mep_pkg::pix_in_t p;
    p.pixel_x = x;
    p.pixel_y = y;
    if (!(word_no >= 300 && word_no < 500) && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start <= 1'b1;
    pix_i <= p;
    do @(posedge clk_i); while (busy);
    sb.note_pixel(p);
    word_no++;
  endtask

  task automatic random_pixels(input int n);
    int w, h;
    w = (sb.frame_w < 2) ? 2 : int'(sb.frame_w);
    h = (sb.frame_h < 2) ? 2 : int'(sb.frame_h);
    repeat (n) begin
      if ($urandom_range(9) == 0)
        send_pixel(12'($urandom_range(4095)), 12'($urandom_range(4095)));
      else
        send_pixel(12'($urandom_range((w > 4096 ? 4096 : w) - 1)),
                   12'($urandom_range((h > 4096 ? 4096 : h) - 1)));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(12'd0, 12'd0);
    send_pixel(12'd639, 12'd479);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd4095);
    send_pixel(12'd4095, 12'd0);
    send_pixel(12'd320, 12'd240);
    send_pixel(12'd455, 12'd240);
    send_pixel(12'd183, 12'd240);
    send_pixel(12'd2730, 12'd1365);
    send_pixel(12'd1365, 12'd2730);
    random_pixels(490);

    configure(2, 2, 1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd1);
    random_pixels(30);

    configure(0, 1, 0);
    send_pixel(12'd0, 12'd0);
    random_pixels(30);

    configure(8191, 8191, 64);
    send_pixel(12'd4095, 12'd4095);
    random_pixels(60);

    configure(4096, 4096, 65535);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1170, 12'd2048);
    send_pixel(12'd4095, 12'd4095);

    configure(100, 75, 1000);
    random_pixels(100);

    configure(17, 3, 16);
    random_pixels(200);

    configure(640, 480, 256);
    random_pixels(100);

    drain();
    repeat (100) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* mandelbrot_escape_time_pixel.f */
+incdir+hdl
hdl/mep_pkg.sv
hdl/mep_ctrl.sv
hdl/mep_dpath.sv
hdl/mandelbrot_escape_time_pixel.sv
test/mandelbrot_escape_time_pixel_test.sv
